// ===== sv/kvt_pkg.sv =====
// Shared constants, codes and word types for the key/value table.
package kvt_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_REPLACE = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_GET     = 3'd3;
    localparam logic [2:0] OP_HAS_KEY = 3'd4;
    localparam logic [2:0] OP_HAS_VAL = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;
    localparam logic [2:0] OP_COUNT   = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] key;
        logic [31:0] value_in;
    } kvt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [4:0]  entry_count;
    } kvt_rsp_t;

    typedef struct packed {
        logic load_in;
        logic capture;
        logic commit;
    } kvt_cmd_t;

    typedef struct packed {
        logic rsp_busy;
    } kvt_stat_t;

endpackage

// ===== sv/key_value_table.sv =====
// Top level of the key/value table: controller plus datapath.
// A request is registered at accept, captured with its compare results, then committed to the response register.
// Requests pass the compare stage then the write-back stage, one request at a time.
// A waiting response holds the write-back stage; the next request enters with its commit.
// Reset clears all valid marks, the entry count and the response valid flag at once.
module key_value_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  kvt_pkg::kvt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output kvt_pkg::kvt_rsp_t rsp
);

    kvt_pkg::kvt_cmd_t  cmd;
    kvt_pkg::kvt_stat_t stat;

    kvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kvt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted during compare");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entry_count <= 5'(kvt_pkg::CAPACITY)))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == kvt_pkg::ST_FULL))
            |-> (rsp.entry_count == 5'(kvt_pkg::CAPACITY)))
        else $error("full status with free entries");

    a_get_only_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != kvt_pkg::ST_OK)) |-> (rsp.value_out == 32'd0))
        else $error("value returned on failed operation");

endmodule

// ===== sv/kvt_ctrl.sv =====
// Sequencer for the key/value table: accept, compare, write back.
module kvt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  kvt_pkg::kvt_stat_t stat,
    output kvt_pkg::kvt_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       can_commit;
    logic       load_in;

    assign can_commit = (state_reg == S_WB) && !stat.rsp_busy;
    assign req_ready  = (state_reg == S_IDLE) || can_commit;
    assign load_in    = req_valid && req_ready;

    assign cmd.load_in = load_in;
    assign cmd.capture = (state_reg == S_CMP);
    assign cmd.commit  = can_commit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (load_in)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (can_commit)
                    state_next = load_in ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/kvt_datapath.sv =====
// Entry store, parallel key/value compare, write-back and response register.
module kvt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  kvt_pkg::kvt_cmd_t  cmd,
    output kvt_pkg::kvt_stat_t stat,
    input  kvt_pkg::kvt_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output kvt_pkg::kvt_rsp_t  rsp
);

    localparam int N = kvt_pkg::CAPACITY;
    localparam int CW = kvt_pkg::COUNT_W;

    logic [31:0]   key_store_reg [N];
    logic [31:0]   value_store_reg [N];
    logic [N-1:0]  valid_reg;
    logic [N-1:0]  valid_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    kvt_pkg::kvt_req_t in_reg;

    logic [2:0]    op2_reg;
    logic [31:0]   key2_reg;
    logic [31:0]   val2_reg;
    logic [N-1:0]  hit_oh2_reg;
    logic          any_hit2_reg;
    logic          val_hit2_reg;
    logic [N-1:0]  free_oh2_reg;
    logic          full2_reg;

    logic [N-1:0]  key_hit;
    logic [N-1:0]  val_hit;
    logic [N-1:0]  free_inv;
    logic [N-1:0]  free_oh;

    logic          rsp_valid_reg;
    kvt_pkg::kvt_rsp_t rsp_reg;

    logic          add_en;
    logic          repl_en;
    logic [1:0]    status_c;
    logic [31:0]   vout_c;
    logic [31:0]   hit_value;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            key_hit[i] = valid_reg[i] && (key_store_reg[i] == in_reg.key);
            val_hit[i] = valid_reg[i] && (value_store_reg[i] == in_reg.value_in);
        end
    end

    assign free_inv = ~valid_reg;
    assign free_oh  = free_inv & (~free_inv + N'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= req;
        if (cmd.capture)
        begin
            op2_reg      <= in_reg.operation;
            key2_reg     <= in_reg.key;
            val2_reg     <= in_reg.value_in;
            hit_oh2_reg  <= key_hit;
            any_hit2_reg <= |key_hit;
            val_hit2_reg <= |val_hit;
            free_oh2_reg <= free_oh;
            full2_reg    <= (count_reg >= CW'(N));
        end
    end

    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < N; i++)
            hit_value = hit_value | (value_store_reg[i] & {32{hit_oh2_reg[i]}});
    end

    always_comb
    begin
        status_c   = kvt_pkg::ST_OK;
        vout_c     = '0;
        valid_next = valid_reg;
        count_next = count_reg;
        add_en     = 1'b0;
        repl_en    = 1'b0;
        case (op2_reg)
            kvt_pkg::OP_ADD:
            begin
                if (any_hit2_reg)
                    status_c = kvt_pkg::ST_DUP;
                else if (full2_reg)
                    status_c = kvt_pkg::ST_FULL;
                else
                begin
                    add_en     = 1'b1;
                    valid_next = valid_reg | free_oh2_reg;
                    count_next = CW'(count_reg + 1'b1);
                end
            end
            kvt_pkg::OP_REPLACE:
            begin
                if (any_hit2_reg)
                    repl_en = 1'b1;
                else
                    status_c = kvt_pkg::ST_ABSENT;
            end
            kvt_pkg::OP_REMOVE:
            begin
                if (any_hit2_reg)
                begin
                    valid_next = valid_reg & ~hit_oh2_reg;
                    count_next = CW'(count_reg - 1'b1);
                end
                else
                    status_c = kvt_pkg::ST_ABSENT;
            end
            kvt_pkg::OP_GET:
            begin
                if (any_hit2_reg)
                    vout_c = hit_value;
                else
                    status_c = kvt_pkg::ST_ABSENT;
            end
            kvt_pkg::OP_HAS_KEY:
            begin
                if (!any_hit2_reg)
                    status_c = kvt_pkg::ST_ABSENT;
            end
            kvt_pkg::OP_HAS_VAL:
            begin
                if (!val_hit2_reg)
                    status_c = kvt_pkg::ST_ABSENT;
            end
            kvt_pkg::OP_CLEAR:
            begin
                valid_next = '0;
                count_next = '0;
            end
            kvt_pkg::OP_COUNT:
            begin
                status_c = kvt_pkg::ST_OK;
            end
            default:
            begin
                status_c = kvt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (cmd.commit && add_en && free_oh2_reg[i])
            begin
                key_store_reg[i]   <= key2_reg;
                value_store_reg[i] <= val2_reg;
            end
            else if (cmd.commit && repl_en && hit_oh2_reg[i])
                value_store_reg[i] <= val2_reg;
        end
        if (cmd.commit)
        begin
            rsp_reg.status      <= status_c;
            rsp_reg.value_out   <= vout_c;
            rsp_reg.entry_count <= 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
            if (cmd.commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign stat.rsp_busy = rsp_valid_reg && !rsp_ready;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

endmodule
